// ----- rtl/lwt_pkg.sv -----
// Package: shared types, constants and register indexes of the look-ahead waypoint tracker.
package lwt_pkg;

    localparam int MAX_WAYPOINTS = 64;
    localparam int IDX_W         = $clog2(MAX_WAYPOINTS);
    localparam int CNT_W         = $clog2(MAX_WAYPOINTS + 1);
    localparam int COORD_W       = 32;
    localparam int DIST_W        = 31;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_W         = DIST_W;
    localparam int SQ_W          = 2 * COORD_W;
    localparam int LIM_W         = 2 * DIST_W;
    localparam int SUM_W         = SQ_W + 2;

    localparam logic [DIST_W-1:0] LOOKAHEAD_RESET = DIST_W'(19661);

    typedef logic [CFG_IDX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_LOOKAHEAD     = 2'd0;
    localparam cfg_index_t REG_LOOP_MODE     = 2'd1;
    localparam cfg_index_t REG_IGNORE_HEIGHT = 2'd2;
    localparam cfg_index_t REG_WAYPOINT_CNT  = 2'd3;

    localparam logic KIND_LOAD     = 1'b0;
    localparam logic KIND_POSITION = 1'b1;

    typedef struct packed {
        logic                      kind;
        logic [IDX_W-1:0]          slot;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
    } in_item_t;

    typedef struct packed {
        logic                      found;
        logic                      path_empty;
        logic [IDX_W-1:0]          target_index;
        logic signed [COORD_W-1:0] target_x;
        logic signed [COORD_W-1:0] target_y;
        logic signed [COORD_W-1:0] target_z;
    } out_item_t;

    typedef struct packed {
        logic             wr_en;
        logic             pos_load;
        logic             issue;
        logic             flush;
        logic [IDX_W-1:0] rd_addr;
        logic             out_load;
        logic             out_found;
        logic             out_empty;
        logic [IDX_W-1:0] out_index;
    } dp_cmd_t;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] hit_index;
        logic             pipe_empty;
        logic [CNT_W-1:0] count;
        logic             loop_mode;
    } dp_status_t;

endpackage

// ----- rtl/lwt_datapath.sv -----
// Datapath: configuration registers, waypoint memory, distance pipeline and result register.
module lwt_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  lwt_pkg::cfg_index_t   cfg_index,
    input  logic [lwt_pkg::CFG_W-1:0] cfg_data,
    input  lwt_pkg::in_item_t     in_data,
    input  lwt_pkg::dp_cmd_t      cmd,
    output lwt_pkg::dp_status_t   status,
    output lwt_pkg::out_item_t    out_data
);
    import lwt_pkg::*;

    function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                    input logic [COORD_W-1:0] b);
        logic signed [COORD_W:0] d;
        logic signed [COORD_W:0] n;
        begin
            d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
            n = -d;
            abs_diff = d[COORD_W] ? n[COORD_W-1:0] : d[COORD_W-1:0];
        end
    endfunction

    logic [DIST_W-1:0]  lookahead_reg;
    logic               loop_mode_reg;
    logic               ignore_height_reg;
    logic [CNT_W-1:0]   waypoint_count_reg;
    logic [LIM_W-1:0]   lim_reg;

    logic [COORD_W-1:0] mem_x [MAX_WAYPOINTS];
    logic [COORD_W-1:0] mem_y [MAX_WAYPOINTS];
    logic [COORD_W-1:0] mem_z [MAX_WAYPOINTS];

    logic [COORD_W-1:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic [COORD_W-1:0] rd_x_reg, rd_y_reg, rd_z_reg;
    logic [COORD_W-1:0] mag_x_reg, mag_y_reg, mag_z_reg;
    logic [SQ_W-1:0]    sq_x_reg, sq_y_reg, sq_z_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic               v1_reg, v2_reg, v3_reg, v4_reg;
    logic [IDX_W-1:0]   tag1_reg, tag2_reg, tag3_reg, tag4_reg;
    out_item_t          out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lookahead_reg      <= LOOKAHEAD_RESET;
            loop_mode_reg      <= 1'b0;
            ignore_height_reg  <= 1'b0;
            waypoint_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LOOKAHEAD:     lookahead_reg      <= cfg_data;
                REG_LOOP_MODE:     loop_mode_reg      <= cfg_data[0];
                REG_IGNORE_HEIGHT: ignore_height_reg  <= cfg_data[0];
                REG_WAYPOINT_CNT:  waypoint_count_reg <= cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // The squared radius is registered from the radius register, so it follows it in the next cycle.
    always_ff @(posedge clk)
    begin
        lim_reg <= lookahead_reg * lookahead_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem_x[in_data.slot] <= in_data.coord_x;
            mem_y[in_data.slot] <= in_data.coord_y;
            mem_z[in_data.slot] <= in_data.coord_z;
        end
        rd_x_reg <= mem_x[cmd.rd_addr];
        rd_y_reg <= mem_y[cmd.rd_addr];
        rd_z_reg <= mem_z[cmd.rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pos_load)
        begin
            pos_x_reg <= in_data.coord_x;
            pos_y_reg <= in_data.coord_y;
            pos_z_reg <= in_data.coord_z;
        end
        tag1_reg  <= cmd.rd_addr;
        tag2_reg  <= tag1_reg;
        tag3_reg  <= tag2_reg;
        tag4_reg  <= tag3_reg;
        mag_x_reg <= abs_diff(rd_x_reg, pos_x_reg);
        mag_y_reg <= abs_diff(rd_y_reg, pos_y_reg);
        mag_z_reg <= abs_diff(rd_z_reg, pos_z_reg);
        sq_x_reg  <= mag_x_reg * mag_x_reg;
        sq_y_reg  <= mag_y_reg * mag_y_reg;
        sq_z_reg  <= mag_z_reg * mag_z_reg;
        sum_reg   <= {2'b00, sq_x_reg} + {2'b00, sq_y_reg}
                   + (ignore_height_reg ? SUM_W'(0) : {2'b00, sq_z_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue && !cmd.flush;
            v2_reg <= v1_reg && !cmd.flush;
            v3_reg <= v2_reg && !cmd.flush;
            v4_reg <= v3_reg && !cmd.flush;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg.found        <= cmd.out_found;
            out_reg.path_empty   <= cmd.out_empty;
            out_reg.target_index <= cmd.out_index;
            out_reg.target_x     <= cmd.out_empty ? '0 : $signed(rd_x_reg);
            out_reg.target_y     <= cmd.out_empty ? '0 : $signed(rd_y_reg);
            out_reg.target_z     <= cmd.out_empty ? '0 : $signed(rd_z_reg);
        end
    end

    always_comb
    begin
        status.hit        = v4_reg && (sum_reg > {{(SUM_W-LIM_W){1'b0}}, lim_reg});
        status.hit_index  = tag4_reg;
        status.pipe_empty = !(v1_reg || v2_reg || v3_reg || v4_reg);
        status.count      = (waypoint_count_reg > CNT_W'(MAX_WAYPOINTS))
                          ? CNT_W'(MAX_WAYPOINTS) : waypoint_count_reg;
        status.loop_mode  = loop_mode_reg;
    end

    assign out_data = out_reg;

endmodule

// ----- rtl/lwt_ctrl.sv -----
// Controller: handshakes, walk sequencing over the waypoint table and target index state.
module lwt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  lwt_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    input  lwt_pkg::dp_status_t status,
    output lwt_pkg::dp_cmd_t    cmd
);
    import lwt_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_FETCH, ST_LOAD} state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] iss_idx_reg, iss_idx_next;
    logic [CNT_W-1:0] iss_cnt_reg, iss_cnt_next;
    logic             iss_done_reg, iss_done_next;
    logic             found_reg, found_next;
    logic             empty_reg, empty_next;
    logic [IDX_W-1:0] final_reg, final_next;
    logic [IDX_W-1:0] target_reg, target_next;
    logic             out_valid_reg, out_valid_next;

    logic             in_accept;
    logic             wrap;
    logic [CNT_W-1:0] eff_idx;
    logic             can_issue;
    logic [CNT_W-1:0] last_idx;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign wrap      = (iss_idx_reg >= status.count);
    assign eff_idx   = wrap ? '0 : iss_idx_reg;
    assign can_issue = !iss_done_reg && (iss_cnt_reg != status.count)
                     && !(wrap && !status.loop_mode);
    assign last_idx  = status.count - CNT_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        iss_idx_next   = iss_idx_reg;
        iss_cnt_next   = iss_cnt_reg;
        iss_done_next  = iss_done_reg;
        found_next     = found_reg;
        empty_next     = empty_reg;
        final_next     = final_reg;
        target_next    = target_reg;
        out_valid_next = out_valid_reg && out_stall;

        cmd           = '0;
        cmd.wr_en     = in_accept && (in_data.kind == KIND_LOAD);
        cmd.pos_load  = in_accept && (in_data.kind == KIND_POSITION);
        cmd.rd_addr   = final_reg;
        cmd.out_found = found_reg;
        cmd.out_empty = empty_reg;
        cmd.out_index = final_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.pos_load)
                begin
                    found_next    = 1'b0;
                    iss_idx_next  = {{(CNT_W-IDX_W){1'b0}}, target_reg};
                    iss_cnt_next  = '0;
                    iss_done_next = 1'b0;
                    final_next    = target_reg;
                    if (status.count == '0)
                    begin
                        empty_next = 1'b1;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        empty_next = 1'b0;
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                if (status.hit)
                begin
                    found_next = 1'b1;
                    final_next = status.hit_index;
                    cmd.flush  = 1'b1;
                    state_next = ST_FETCH;
                end
                else if (iss_done_reg && status.pipe_empty)
                begin
                    final_next = status.loop_mode ? eff_idx[IDX_W-1:0] : last_idx[IDX_W-1:0];
                    state_next = ST_FETCH;
                end
                else if (can_issue)
                begin
                    cmd.issue    = 1'b1;
                    cmd.rd_addr  = eff_idx[IDX_W-1:0];
                    iss_idx_next = eff_idx + CNT_W'(1);
                    iss_cnt_next = iss_cnt_reg + CNT_W'(1);
                end
                else
                begin
                    iss_done_next = 1'b1;
                end
            end
            ST_FETCH:
            begin
                target_next = final_reg;
                state_next  = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            iss_idx_reg   <= '0;
            iss_cnt_reg   <= '0;
            iss_done_reg  <= 1'b0;
            found_reg     <= 1'b0;
            empty_reg     <= 1'b0;
            final_reg     <= '0;
            target_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iss_idx_reg   <= iss_idx_next;
            iss_cnt_reg   <= iss_cnt_next;
            iss_done_reg  <= iss_done_next;
            found_reg     <= found_next;
            empty_reg     <= empty_next;
            final_reg     <= final_next;
            target_reg    <= target_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_hit_only_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        status.hit |-> state_reg == ST_WALK)
        else $error("distance hit outside of a walk");

    a_issue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> {{(CNT_W-IDX_W){1'b0}}, cmd.rd_addr} < status.count)
        else $error("table read issued beyond the waypoint count");

    a_walk_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK |-> iss_cnt_reg <= status.count)
        else $error("walk covered more entries than the path holds");

    a_load_gives_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid)
        else $error("result load did not raise the output valid");

endmodule

// ----- rtl/lookahead_waypoint_tracker_top.sv -----
// Top level: look-ahead waypoint tracker built from a controller and a datapath.
//
// Input channel (in_valid, in_stall, in_data): a transfer takes place when in_valid is high
// and in_stall is low. A load item (kind 0) writes one waypoint table entry and gives no
// result. A position item (kind 1) starts a walk from the stored target index; it gives
// exactly one result on the output channel (out_valid, out_stall, out_data). The walk
// reads one table entry per cycle through a four-stage distance pipeline and stops at the
// first waypoint beyond the look-ahead radius, visiting at most as many entries as the
// waypoint count (64 here). An empty path answers without a walk. in_stall stays high
// while a position item is in work. The result sits in an output register; the block
// takes the next item while it waits, and beyond the walk stalls only when a second
// result is ready and the first is still held by out_stall. Configuration (cfg_we,
// cfg_index, cfg_data) writes one register per cycle and must be used only while the
// block is idle. Reset clears the target index, sets the look-ahead radius to 0.3 m and
// the waypoint count to zero; table contents are undefined until loaded.
module lookahead_waypoint_tracker_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  lwt_pkg::cfg_index_t       cfg_index,
    input  logic [lwt_pkg::CFG_W-1:0] cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  lwt_pkg::in_item_t         in_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output lwt_pkg::out_item_t        out_data
);
    import lwt_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    lwt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    lwt_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_data  (out_data)
    );

endmodule

// ----- tb/sv/tb_lookahead_waypoint_tracker_top.sv -----
// Testbench: random waypoint loads and position updates for the look-ahead waypoint tracker, with every target result checked.
`timescale 1ns / 100ps

module tb_lookahead_waypoint_tracker_top;
    import lwt_pkg::*;

    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned RANDOM_PHASES = 48;
    localparam int unsigned ITEMS_PER_PHASE = 32;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            cfg_we;
    cfg_index_t      cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic            in_valid;
    logic            in_stall;
    in_item_t        in_data;
    logic            out_valid;
    logic            out_stall;
    out_item_t       out_data;

    lookahead_waypoint_tracker_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    // Tracker state as the block should hold it.
    logic signed [COORD_W-1:0] tbl_x [MAX_WAYPOINTS];
    logic signed [COORD_W-1:0] tbl_y [MAX_WAYPOINTS];
    logic signed [COORD_W-1:0] tbl_z [MAX_WAYPOINTS];
    int unsigned               aim_index;
    logic [DIST_W-1:0]         cfg_radius;
    logic                      cfg_wrap;
    logic                      cfg_flat;
    logic [6:0]                cfg_count;

    // Stimulus generator's own view of the table contents.
    logic signed [COORD_W-1:0] plan_x [MAX_WAYPOINTS];
    logic signed [COORD_W-1:0] plan_y [MAX_WAYPOINTS];
    logic signed [COORD_W-1:0] plan_z [MAX_WAYPOINTS];

    in_item_t    item_backlog [$];
    out_item_t   expected_targets [$];
    int unsigned err_count = 0;
    bit          steady = 1'b0;
    int unsigned gap_left;
    int unsigned gap_draw;
    int unsigned stall_left;
    int unsigned stall_draw;
    int unsigned quiet_cycles = 0;

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [SQ_W-1:0] sq_diff(logic signed [COORD_W-1:0] a,
                                                logic signed [COORD_W-1:0] b);
        logic [COORD_W:0]   d;
        logic [COORD_W-1:0] m;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        m = d[COORD_W] ? ~d[COORD_W-1:0] + 32'd1 : d[COORD_W-1:0];
        return {32'd0, m} * {32'd0, m};
    endfunction

    function automatic bit outside_radius(int unsigned idx, in_item_t p);
        logic [SUM_W-1:0] lim;
        logic [SUM_W-1:0] dist2;
        lim = SUM_W'(cfg_radius) * SUM_W'(cfg_radius);
        dist2 = SUM_W'(sq_diff(tbl_x[idx], p.coord_x)) + SUM_W'(sq_diff(tbl_y[idx], p.coord_y));
        if (!cfg_flat)
            dist2 = dist2 + SUM_W'(sq_diff(tbl_z[idx], p.coord_z));
        return dist2 > lim;
    endfunction

    task automatic track_item(input in_item_t it);
        int unsigned cnt;
        int unsigned idx;
        int unsigned i;
        bit          hit;
        out_item_t   res;
        if (it.kind == KIND_LOAD)
        begin
            tbl_x[it.slot] = it.coord_x;
            tbl_y[it.slot] = it.coord_y;
            tbl_z[it.slot] = it.coord_z;
            return;
        end
        cnt = (cfg_count > MAX_WAYPOINTS) ? MAX_WAYPOINTS : cfg_count;
        res = '0;
        if (cnt == 0)
        begin
            res.path_empty = 1'b1;
            res.target_index = aim_index[IDX_W-1:0];
            expected_targets.push_back(res);
            return;
        end
        idx = aim_index;
        hit = 1'b0;
        for (i = 0; i < cnt; i++)
        begin
            if (idx >= cnt)
            begin
                idx = 0;
                if (!cfg_wrap)
                    break;
            end
            if (outside_radius(idx, it))
            begin
                hit = 1'b1;
                break;
            end
            idx++;
        end
        if (!hit)
        begin
            if (!cfg_wrap)
                idx = cnt - 1;
            else if (idx >= cnt)
                idx = 0;
        end
        aim_index = idx;
        res.found = hit;
        res.target_index = idx[IDX_W-1:0];
        res.target_x = tbl_x[idx];
        res.target_y = tbl_y[idx];
        res.target_z = tbl_z[idx];
        expected_targets.push_back(res);
    endtask

    task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
        $display("ERROR at %0t: %s expected %h got %h", $realtime, what, want, got);
        err_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                track_item(in_data);
                gap_draw = pick_gap();
                if (gap_draw == 0 && item_backlog.size() > 0)
                    in_data <= item_backlog.pop_front();
                else
                begin
                    in_valid <= 1'b0;
                    gap_left <= gap_draw;
                end
            end
            else if (!in_valid)
            begin
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
                else if (item_backlog.size() > 0)
                begin
                    in_data <= item_backlog.pop_front();
                    in_valid <= 1'b1;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_targets.size() == 0)
                    report_mismatch("unexpected result, target_index", '0, out_data.target_index);
                else
                begin
                    out_item_t want;
                    want = expected_targets.pop_front();
                    if (out_data.found !== want.found)
                        report_mismatch("found", want.found, out_data.found);
                    if (out_data.path_empty !== want.path_empty)
                        report_mismatch("path_empty", want.path_empty, out_data.path_empty);
                    if (out_data.target_index !== want.target_index)
                        report_mismatch("target_index", want.target_index, out_data.target_index);
                    if (out_data.target_x !== want.target_x)
                        report_mismatch("target_x", want.target_x, out_data.target_x);
                    if (out_data.target_y !== want.target_y)
                        report_mismatch("target_y", want.target_y, out_data.target_y);
                    if (out_data.target_z !== want.target_z)
                        report_mismatch("target_z", want.target_z, out_data.target_z);
                end
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else
            begin
                stall_draw = pick_gap();
                out_stall <= (stall_draw != 0);
                if (stall_draw != 0)
                    stall_left <= stall_draw - 1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic add_pos(int x, int y, int z);
        in_item_t it;
        it.kind = KIND_POSITION;
        it.slot = IDX_W'($urandom_range(0, MAX_WAYPOINTS - 1));
        it.coord_x = x;
        it.coord_y = y;
        it.coord_z = z;
        item_backlog.push_back(it);
    endtask

    task automatic add_load(int unsigned slot, int x, int y, int z);
        in_item_t it;
        it.kind = KIND_LOAD;
        it.slot = slot[IDX_W-1:0];
        it.coord_x = x;
        it.coord_y = y;
        it.coord_z = z;
        plan_x[it.slot] = x;
        plan_y[it.slot] = y;
        plan_z[it.slot] = z;
        item_backlog.push_back(it);
    endtask

    task automatic add_near(int unsigned len, int unsigned span);
        int unsigned k;
        k = $urandom_range(0, len - 1);
        add_pos(plan_x[k] + int'($urandom_range(0, 2 * span)) - int'(span),
                plan_y[k] + int'($urandom_range(0, 2 * span)) - int'(span),
                plan_z[k] + int'($urandom_range(0, 2 * span)) - int'(span));
    endtask

    task automatic lay_path(int unsigned len, int unsigned stride);
        int          px;
        int          py;
        int          pz;
        int unsigned i;
        px = int'($urandom_range(0, 1 << 23)) - (1 << 22);
        py = int'($urandom_range(0, 1 << 23)) - (1 << 22);
        pz = int'($urandom_range(0, 1 << 20)) - (1 << 19);
        for (i = 0; i < len; i++)
        begin
            add_load(i, px, py, pz);
            px += int'($urandom_range(stride / 2, 2 * stride));
            py += int'($urandom_range(0, stride)) - int'(stride / 2);
            pz += int'($urandom_range(0, stride / 4)) - int'(stride / 8);
        end
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            REG_LOOKAHEAD:     cfg_radius = data[DIST_W-1:0];
            REG_LOOP_MODE:     cfg_wrap = data[0];
            REG_IGNORE_HEIGHT: cfg_flat = data[0];
            REG_WAYPOINT_CNT:  cfg_count = data[6:0];
            default:           ;
        endcase
    endtask

    task automatic configure(logic [DIST_W-1:0] radius, logic wrap, logic flat,
                             logic [6:0] count);
        write_reg(REG_LOOKAHEAD, radius);
        write_reg(REG_LOOP_MODE, (CFG_W'($urandom()) & ~CFG_W'(1)) | CFG_W'(wrap));
        write_reg(REG_IGNORE_HEIGHT, (CFG_W'($urandom()) & ~CFG_W'(1)) | CFG_W'(flat));
        write_reg(REG_WAYPOINT_CNT, (CFG_W'($urandom()) & ~CFG_W'(7'h7F)) | CFG_W'(count));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic settle();
        @(posedge clk);
        while (item_backlog.size() != 0 || in_valid || expected_targets.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    initial
    begin
        int unsigned       ph;
        int unsigned       n;
        int unsigned       r;
        int unsigned       i;
        int unsigned       plan_len;
        int unsigned       stride;
        logic [DIST_W-1:0] radius;
        logic [6:0]        count;

        cfg_we <= 1'b0;
        cfg_index <= REG_LOOKAHEAD;
        cfg_data <= '0;
        aim_index = 0;
        cfg_radius = LOOKAHEAD_RESET;
        cfg_wrap = 1'b0;
        cfg_flat = 1'b0;
        cfg_count = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // An empty path answers with the flag before any entry is loaded.
        add_pos(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_pos(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_load(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_load(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_load(2, 0, 0, 0);
        add_load(3, 0, 0, 1 << 20);
        for (i = 4; i < 8; i++)
            add_load(i, $urandom(), $urandom(), $urandom());
        for (i = 8; i < MAX_WAYPOINTS; i++)
            add_load(i, int'($urandom_range(0, 1 << 21)) - (1 << 20),
                     int'($urandom_range(0, 1 << 21)) - (1 << 20),
                     int'($urandom_range(0, 1 << 21)) - (1 << 20));
        settle();

        configure(31'h7FFF_FFFF, 1'b0, 1'b0, 7'd127);
        add_pos(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_pos(0, 0, 0);
        settle();
        configure('0, 1'b0, 1'b0, 7'd4);
        add_pos(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_pos(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_pos(0, 0, 0);
        settle();
        configure(31'd65536, 1'b0, 1'b1, 7'd4);
        add_pos(0, 0, 1 << 30);
        add_pos(0, 0, 0);
        settle();
        configure(31'd65536, 1'b1, 1'b0, 7'd4);
        add_pos(0, 0, 0);
        add_pos(0, 0, 1 << 20);
        settle();
        configure(31'h7FFF_FFFF, 1'b1, 1'b1, 7'd3);
        add_pos(0, 0, 0);
        add_pos(1 << 28, 1 << 28, 0);
        settle();
        // Shrinking the count to two entries leaves the stored target within the path.
        configure(31'd65536, 1'b0, 1'b0, 7'd2);
        add_pos(0, 0, 1 << 20);
        settle();
        configure(31'd65536, 1'b1, 1'b0, 7'd1);
        add_pos(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_pos(32'h7FFF_FFFF, 0, 0);
        settle();
        configure(LOOKAHEAD_RESET, 1'b1, 1'b1, 7'd64);
        add_pos($urandom(), $urandom(), $urandom());
        add_pos(0, 0, 0);
        settle();

        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            steady = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 9);
            if (r == 0)
                radius = '0;
            else if (r == 1)
                radius = 31'h7FFF_FFFF;
            else if (r == 2)
                radius = DIST_W'($urandom());
            else
                radius = DIST_W'($urandom_range(1 << 14, 1 << 19));
            r = $urandom_range(0, 9);
            if (r == 0)
                count = '0;
            else if (r == 1)
                count = 7'd64;
            else if (r == 2)
                count = 7'($urandom_range(65, 127));
            else
                count = 7'($urandom_range(1, 12));
            configure(radius, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), count);
            plan_len = (count > MAX_WAYPOINTS) ? MAX_WAYPOINTS : count;
            stride = ((radius > (1 << 22)) ? (1 << 22) : radius) + 64;
            if (plan_len > 0 && $urandom_range(0, 1) == 1)
                lay_path(plan_len, stride);
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 72 && plan_len > 0)
                    add_near(plan_len, stride + stride / 2);
                else if (r < 86)
                    add_load($urandom_range(0, MAX_WAYPOINTS - 1),
                             $urandom(), $urandom(), $urandom());
                else
                    add_pos($urandom(), $urandom(), $urandom());
            end
            settle();
        end

        steady = 1'b0;
        repeat (100) @(posedge clk);
        if (expected_targets.size() != 0)
            report_mismatch("results never delivered", '0, expected_targets.size());
        if (err_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- lookahead_waypoint_tracker_top.f -----
rtl/lwt_pkg.sv
rtl/lwt_datapath.sv
rtl/lwt_ctrl.sv
rtl/lookahead_waypoint_tracker_top.sv
tb/sv/tb_lookahead_waypoint_tracker_top.sv
